FILE: hdl/nand_command_cycle_sequencer_defines.svh
`ifndef NAND_COMMAND_CYCLE_SEQUENCER_DEFINES_SVH
`define NAND_COMMAND_CYCLE_SEQUENCER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define NCCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define NCCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/nccs_pkg.sv
`timescale 1ns / 1ps

package nccs_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned CFG_DATA_W  = 16;

	typedef enum logic [2:0] {
		OP_RESET         = 3'd0,
		OP_READ_ID       = 3'd1,
		OP_ERASE         = 3'd2,
		OP_PAGE_READ     = 3'd3,
		OP_PAGE_PROGRAM  = 3'd4,
		OP_READ_STATUS   = 3'd5,
		OP_DECODE_STATUS = 3'd6
	} op_t;

	typedef enum logic [2:0] {
		KIND_CMD    = 3'd0,
		KIND_ADDR   = 3'd1,
		KIND_RBURST = 3'd2,
		KIND_WBURST = 3'd3,
		KIND_STATUS = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FAILED    = 2'd1,
		ST_NOT_READY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CFG_SHORT_PAGE       = 3'd0,
		CFG_BUS_16BIT        = 3'd1,
		CFG_LARGE_CAPACITY   = 3'd2,
		CFG_READ_PAGE_BYTES  = 3'd3,
		CFG_WRITE_PAGE_BYTES = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PH_HEAD = 2'd0,
		PH_ADDR = 2'd1,
		PH_TAIL = 2'd2
	} phase_t;

	// NAND command opcodes.
	localparam logic [7:0] CMD_READ_SETUP      = 8'h00;
	localparam logic [7:0] CMD_READ_CONFIRM    = 8'h30;
	localparam logic [7:0] CMD_ERASE_SETUP     = 8'h60;
	localparam logic [7:0] CMD_ERASE_CONFIRM   = 8'hD0;
	localparam logic [7:0] CMD_PROGRAM_SETUP   = 8'h80;
	localparam logic [7:0] CMD_PROGRAM_CONFIRM = 8'h10;
	localparam logic [7:0] CMD_READ_ID         = 8'h90;
	localparam logic [7:0] CMD_RESET           = 8'hFF;
	localparam logic [7:0] CMD_READ_STATUS     = 8'h70;

	localparam logic [7:0]  READ_ID_ADDR      = 8'h00;
	localparam logic [15:0] READ_ID_BYTES     = 16'd4;
	localparam logic [15:0] STATUS_BYTES      = 16'd1;
	localparam logic [15:0] PAGE_BYTES_RESET  = 16'd2048;

	localparam logic [31:0] SHORT_PAGE_MASK = 32'hFFFF_FE00;
	localparam logic [31:0] LARGE_COL_MASK  = 32'h0000_0FFF;
	localparam logic [31:0] LARGE_ROW_MASK  = 32'hFFFF_0000;

	localparam int unsigned STATUS_FAIL_BIT  = 0;
	localparam int unsigned STATUS_READY_BIT = 6;

	typedef struct packed {
		logic            short_page;
		logic            bus_16bit;
		logic            large_capacity;
		logic [15:0]     read_page_bytes;
		logic [15:0]     write_page_bytes;
	} cfg_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [15:0] len;
		status_t     code;
	} item_t;

	// One classified operation: a leading cycle, up to four address bytes taken
	// little-endian from addr_word, then up to two trailing cycles.
	typedef struct packed {
		item_t           head;
		logic [31:0]     addr_word;
		logic [2:0]      n_addr;
		logic [1:0]      n_tail;
		item_t [1:0]     tail;
	} job_t;

	function automatic item_t mk_item(kind_t k, logic [7:0] b, logic [15:0] l, status_t c);
		item_t it;
		it.kind = k;
		it.data = b;
		it.len  = l;
		it.code = c;
		return it;
	endfunction

endpackage

FILE: hdl/nccs_if.sv
`timescale 1ns / 1ps

interface nccs_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [31:0] byte_address;
	logic [7:0]  status_byte;

	modport source (output valid, output operation, output byte_address,
		output status_byte, input ready);
	modport sink (input valid, input operation, input byte_address,
		input status_byte, output ready);
endinterface

interface nccs_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cycle_kind;
	logic [7:0]  cycle_byte;
	logic [15:0] burst_length;
	logic [1:0]  status_code;
	logic        last;

	modport source (output valid, output cycle_kind, output cycle_byte,
		output burst_length, output status_code, output last, input ready);
	modport sink (input valid, input cycle_kind, input cycle_byte,
		input burst_length, input status_code, input last, output ready);
endinterface

FILE: hdl/nccs_front.sv
`timescale 1ns / 1ps

module nccs_front (
	nccs_in_if.sink        req,
	input  nccs_pkg::cfg_t cfg,
	input  logic           q_full,
	output logic           push,
	output nccs_pkg::job_t job
);
	import nccs_pkg::*;

	op_t         op;
	logic [31:0] addr;
	logic [31:0] addr_half;
	logic [31:0] page_word;
	logic [31:0] erase_word;
	logic [31:0] large_word;
	logic [2:0]  n_page;
	logic [15:0] rd_len;
	logic [15:0] wr_len;
	status_t     st_code;
	logic        known_op;

	always_comb begin
		op   = op_t'(req.operation);
		addr = req.byte_address;

		// Large-page column and row are taken from the word address on a 16-bit bus.
		addr_half  = cfg.bus_16bit ? {1'b0, addr[31:1]} : addr;
		page_word  = cfg.short_page ? ((addr & SHORT_PAGE_MASK) >> 1)
			: ((addr_half & LARGE_COL_MASK) | ((addr_half << 4) & LARGE_ROW_MASK));
		// Erase sends only the row and always uses the byte address.
		large_word = (addr & LARGE_COL_MASK) | ((addr << 4) & LARGE_ROW_MASK);
		erase_word = cfg.short_page ? ((addr & SHORT_PAGE_MASK) >> 9) : (large_word >> 16);
		n_page     = cfg.large_capacity ? 3'd4 : 3'd3;
		rd_len     = cfg.bus_16bit ? {1'b0, cfg.read_page_bytes[15:1]} : cfg.read_page_bytes;
		wr_len     = cfg.bus_16bit ? {1'b0, cfg.write_page_bytes[15:1]} : cfg.write_page_bytes;

		if (req.status_byte[STATUS_FAIL_BIT]) begin
			st_code = ST_FAILED;
		end else if (req.status_byte[STATUS_READY_BIT]) begin
			st_code = ST_OK;
		end else begin
			st_code = ST_NOT_READY;
		end

		job          = '0;
		job.head     = mk_item(KIND_CMD, CMD_RESET, 16'd0, ST_OK);
		job.tail[0]  = mk_item(KIND_CMD, CMD_RESET, 16'd0, ST_OK);
		job.tail[1]  = mk_item(KIND_CMD, CMD_RESET, 16'd0, ST_OK);
		known_op     = 1'b1;

		case (op)
			OP_RESET: begin
				job.head = mk_item(KIND_CMD, CMD_RESET, 16'd0, ST_OK);
			end
			OP_READ_ID: begin
				job.head      = mk_item(KIND_CMD, CMD_READ_ID, 16'd0, ST_OK);
				job.addr_word = {24'd0, READ_ID_ADDR};
				job.n_addr    = 3'd1;
				job.n_tail    = 2'd1;
				job.tail[0]   = mk_item(KIND_RBURST, 8'd0, READ_ID_BYTES, ST_OK);
			end
			OP_ERASE: begin
				job.head      = mk_item(KIND_CMD, CMD_ERASE_SETUP, 16'd0, ST_OK);
				job.addr_word = erase_word;
				job.n_addr    = cfg.short_page ? 3'd3 : 3'd2;
				job.n_tail    = 2'd1;
				job.tail[0]   = mk_item(KIND_CMD, CMD_ERASE_CONFIRM, 16'd0, ST_OK);
			end
			OP_PAGE_READ: begin
				job.head      = mk_item(KIND_CMD, CMD_READ_SETUP, 16'd0, ST_OK);
				job.addr_word = page_word;
				job.n_addr    = n_page;
				job.n_tail    = 2'd2;
				job.tail[0]   = mk_item(KIND_CMD, CMD_READ_CONFIRM, 16'd0, ST_OK);
				job.tail[1]   = mk_item(KIND_RBURST, 8'd0, rd_len, ST_OK);
			end
			OP_PAGE_PROGRAM: begin
				job.head      = mk_item(KIND_CMD, CMD_PROGRAM_SETUP, 16'd0, ST_OK);
				job.addr_word = page_word;
				job.n_addr    = n_page;
				job.n_tail    = 2'd2;
				job.tail[0]   = mk_item(KIND_WBURST, 8'd0, wr_len, ST_OK);
				job.tail[1]   = mk_item(KIND_CMD, CMD_PROGRAM_CONFIRM, 16'd0, ST_OK);
			end
			OP_READ_STATUS: begin
				job.head    = mk_item(KIND_CMD, CMD_READ_STATUS, 16'd0, ST_OK);
				job.n_tail  = 2'd1;
				job.tail[0] = mk_item(KIND_RBURST, 8'd0, STATUS_BYTES, ST_OK);
			end
			OP_DECODE_STATUS: begin
				job.head = mk_item(KIND_STATUS, 8'd0, 16'd0, st_code);
			end
			default: begin
				known_op = 1'b0;
			end
		endcase

		// An unused code is taken and dropped, since it produces no cycles.
		req.ready = !q_full;
		push      = req.valid && !q_full && known_op;
	end

endmodule

FILE: hdl/nccs_queue.sv
`timescale 1ns / 1ps
`include "nand_command_cycle_sequencer_defines.svh"

module nccs_queue #(
	parameter int unsigned DEPTH = nccs_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  nccs_pkg::job_t job_in,
	output logic           full,
	input  logic           pop,
	output nccs_pkg::job_t job_out,
	output logic           not_empty
);
	import nccs_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	job_t          slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= job_in;
		end
	end

	assign job_out   = slot_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == FULL_COUNT);

	`NCCS_ASSERT_NOW(a_no_overflow, clk, arst_n, push, count_q != FULL_COUNT, "queue overflow")
	`NCCS_ASSERT_NOW(a_no_underflow, clk, arst_n, pop, count_q != '0, "queue underflow")
	`NCCS_ASSERT_NEXT(a_count_up, clk, arst_n, push && !pop, count_q == $past(count_q) + 1'b1, "count lost a push")

endmodule

FILE: hdl/nccs_back.sv
`timescale 1ns / 1ps
`include "nand_command_cycle_sequencer_defines.svh"

module nccs_back (
	input  logic           clk,
	input  logic           arst_n,
	input  nccs_pkg::job_t job,
	input  logic           job_valid,
	output logic           pop,
	nccs_out_if.source     rsp
);
	import nccs_pkg::*;

	phase_t      state_q;
	phase_t      state_d;
	logic [1:0]  addr_idx_q;
	logic [1:0]  addr_idx_d;
	logic        tail_idx_q;
	logic        tail_idx_d;
	item_t       cur;
	logic        cur_last;
	logic        adv;
	logic        step;

	logic        valid_q;
	kind_t       kind_q;
	logic [7:0]  byte_q;
	logic [15:0] len_q;
	status_t     code_q;
	logic        last_q;

	assign adv  = !valid_q || rsp.ready;
	assign step = adv && job_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= PH_HEAD;
			addr_idx_q <= '0;
			tail_idx_q <= 1'b0;
		end else if (step) begin
			state_q    <= state_d;
			addr_idx_q <= addr_idx_d;
			tail_idx_q <= tail_idx_d;
		end
	end

	always_comb begin
		cur        = job.head;
		cur_last   = 1'b0;
		state_d    = state_q;
		addr_idx_d = addr_idx_q;
		tail_idx_d = tail_idx_q;

		case (state_q)
			PH_HEAD: begin
				cur = job.head;
				if (job.n_addr != 3'd0) begin
					state_d = PH_ADDR;
				end else if (job.n_tail != 2'd0) begin
					state_d = PH_TAIL;
				end else begin
					cur_last = 1'b1;
				end
			end
			PH_ADDR: begin
				cur = mk_item(KIND_ADDR, job.addr_word[8*addr_idx_q +: 8], 16'd0, ST_OK);
				if ({1'b0, addr_idx_q} + 3'd1 == job.n_addr) begin
					addr_idx_d = '0;
					if (job.n_tail != 2'd0) begin
						state_d = PH_TAIL;
					end else begin
						state_d  = PH_HEAD;
						cur_last = 1'b1;
					end
				end else begin
					addr_idx_d = addr_idx_q + 2'd1;
				end
			end
			PH_TAIL: begin
				cur = job.tail[tail_idx_q];
				if ({1'b0, tail_idx_q} + 2'd1 == job.n_tail) begin
					state_d    = PH_HEAD;
					tail_idx_d = 1'b0;
					cur_last   = 1'b1;
				end else begin
					tail_idx_d = 1'b1;
				end
			end
			default: begin
				state_d = PH_HEAD;
			end
		endcase

		pop = step && cur_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= job_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			kind_q <= cur.kind;
			byte_q <= cur.data;
			len_q  <= cur.len;
			code_q <= cur.code;
			last_q <= cur_last;
		end
	end

	assign rsp.valid        = valid_q;
	assign rsp.cycle_kind   = kind_q;
	assign rsp.cycle_byte   = byte_q;
	assign rsp.burst_length = len_q;
	assign rsp.status_code  = code_q;
	assign rsp.last         = last_q;

	`NCCS_ASSERT_NEXT(a_pop_marks_last, clk, arst_n, pop, valid_q && last_q, "job retired without last")
	`NCCS_ASSERT_NOW(a_mid_job_has_job, clk, arst_n, state_q != PH_HEAD, job_valid, "mid-job with empty queue")
	`NCCS_ASSERT_NOW(a_addr_in_range, clk, arst_n, state_q == PH_ADDR, {1'b0, addr_idx_q} < job.n_addr, "address index past end")

endmodule

FILE: hdl/nand_command_cycle_sequencer.sv
`timescale 1ns / 1ps

// NAND command cycle sequencer. Each request on req names one operation (reset, read ID, block
// erase, page read, page program, read status or status decode) and the block answers on rsp with
// the run of bus cycles it needs, one result per request-cycle: command opcodes, address bytes
// least significant first, read or write bursts given by their transfer count, or a decoded status.
// The final result of a run carries last. Results leave at one per clock whenever rsp is ready.
// An operation has one result for reset and status decode, two for read status, three for read
// ID, four or five for erase, six or seven for page read and program. When the block is idle,
// an accepted request is first written into the job queue, and its first result is then
// registered in the back end's output register, from which it is presented on rsp.
// The classifying front end accepts a request per cycle while the two-entry job queue has room,
// so requests are taken while earlier runs are still being played out; the back end's result
// rate of one per clock is what sets the sustained figure. Operation code 7 is accepted and
// produces no cycles. The configuration registers (page geometry, bus width, capacity and page
// sizes) are written through cfg_we, cfg_index and cfg_data and must only be changed while no run
// is outstanding.

module nand_command_cycle_sequencer #(
	parameter int unsigned QUEUE_DEPTH = nccs_pkg::QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [2:0]                      cfg_index,
	input  logic [nccs_pkg::CFG_DATA_W-1:0] cfg_data,
	nccs_in_if.sink                         req,
	nccs_out_if.source                      rsp
);
	import nccs_pkg::*;

	cfg_t cfg_q;
	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_not_empty;
	job_t job_front;
	job_t job_back;

	// Configuration registers; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_page       <= 1'b0;
			cfg_q.bus_16bit        <= 1'b0;
			cfg_q.large_capacity   <= 1'b0;
			cfg_q.read_page_bytes  <= PAGE_BYTES_RESET;
			cfg_q.write_page_bytes <= PAGE_BYTES_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SHORT_PAGE:       cfg_q.short_page       <= cfg_data[0];
				CFG_BUS_16BIT:        cfg_q.bus_16bit        <= cfg_data[0];
				CFG_LARGE_CAPACITY:   cfg_q.large_capacity   <= cfg_data[0];
				CFG_READ_PAGE_BYTES:  cfg_q.read_page_bytes  <= cfg_data[15:0];
				CFG_WRITE_PAGE_BYTES: cfg_q.write_page_bytes <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// The front end turns each request into a job: the leading cycle, the address word and
	// its byte count, and the trailing cycles, all resolved against the current configuration.
	nccs_front u_front (
		.req    (req),
		.cfg    (cfg_q),
		.q_full (q_full),
		.push   (q_push),
		.job    (job_front)
	);

	// The queue decouples acceptance from playback, so either side may stall alone.
	nccs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.job_in    (job_front),
		.full      (q_full),
		.pop       (q_pop),
		.job_out   (job_back),
		.not_empty (q_not_empty)
	);

	// The back end steps through the job one bus cycle at a time into its output register and
	// retires the job with the result that carries last.
	nccs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job_back),
		.job_valid (q_not_empty),
		.pop       (q_pop),
		.rsp       (rsp)
	);

endmodule
